// ===== rtl/s2d_pkg.sv =====
// shared constants, types and helper functions for the decimal ascii converter
`default_nettype none

package s2d_pkg;

    // bcd digit layout and double-dabble step size
    localparam int DIGIT_W       = 4;
    localparam int BITS_PER_STEP = 4;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } t_front_state;

    // decimal digits needed for any unsigned value of the given width
    function automatic int num_digits(input int width);
        return ((width * 1233) >> 12) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/s2d_fifo.sv =====
// small register queue between the converter and the character emitter
`default_nettype none

module s2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/s2d_front.sv =====
// input side: sign split, magnitude and shift-add-3 binary to bcd conversion
`default_nettype none

module s2d_front
    import s2d_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_value,
    output logic             o_push,
    input  wire logic        i_full,
    output logic [1 + $clog2(num_digits(VALUE_WIDTH)) + num_digits(VALUE_WIDTH)*DIGIT_W - 1:0]
                             o_entry
);

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W = STEPS * BITS_PER_STEP;
    localparam int NDIG  = num_digits(VALUE_WIDTH);
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(STEPS + 1);

    t_front_state r_state;
    t_front_state n_state;

    logic                   r_neg;
    logic [MAG_W-1:0]       r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic [CNT_W-1:0]       r_cnt;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   raw_neg;
    logic [VALUE_WIDTH-1:0] raw_mag;
    logic [BCD_W-1:0]       bcd_v;
    logic [MAG_W-1:0]       mag_v;
    logic [IDX_W-1:0]       top_idx;
    logic                   accept;

    assign raw     = i_value[VALUE_WIDTH-1:0];
    assign raw_neg = raw[VALUE_WIDTH-1];
    assign raw_mag = raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign accept  = i_valid & o_ready;

    // several dabble steps per cycle: add 3 to digits of 5 or more, then shift
    always_comb begin
        bcd_v = r_bcd;
        mag_v = r_mag;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_v[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
                    bcd_v[d*DIGIT_W +: DIGIT_W] = bcd_v[d*DIGIT_W +: DIGIT_W] + DABBLE_ADJ;
                end
            end
            {bcd_v, mag_v} = {bcd_v, mag_v} << 1;
        end
    end

    // highest nonzero digit; zero leaves index 0 so a single '0' goes out
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign o_entry = {r_neg, top_idx, r_bcd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            FRONT_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = FRONT_CONV;
                end
            end
            FRONT_CONV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                o_push = ~i_full;
                if (!i_full) begin
                    n_state = FRONT_IDLE;
                end
            end
            default: begin
                n_state = FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= raw_neg;
            r_mag <= MAG_W'(raw_mag);
            r_bcd <= '0;
            r_cnt <= CNT_W'(STEPS);
        end else if (r_state == FRONT_CONV) begin
            r_mag <= mag_v;
            r_bcd <= bcd_v;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/s2d_back.sv =====
// output side: emits sign and digits, one character per accepted transfer
`default_nettype none

module s2d_back
    import s2d_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire logic [1 + $clog2(num_digits(VALUE_WIDTH)) + num_digits(VALUE_WIDTH)*DIGIT_W - 1:0]
                            i_entry,
    output logic            o_pop,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    localparam int NDIG  = num_digits(VALUE_WIDTH);
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int IDX_W = $clog2(NDIG);

    logic               r_busy;
    logic               r_neg;
    logic [IDX_W-1:0]   r_idx;
    logic [BCD_W-1:0]   r_bcd;

    logic               fire;
    logic               finishing;
    logic               load;
    logic [DIGIT_W-1:0] digit;

    assign fire      = r_busy & i_tready;
    assign finishing = fire & ~r_neg & (r_idx == '0);
    assign load      = ~i_empty & (~r_busy | finishing);
    assign o_pop     = load;

    assign digit    = r_bcd[r_idx*DIGIT_W +: DIGIT_W];
    assign o_tvalid = r_busy;
    assign o_tdata  = r_neg ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
    assign o_tlast  = ~r_neg & (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (finishing) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            {r_neg, r_idx, r_bcd} <= i_entry;
        end else if (fire) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/signed_integer_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii text, front converter, queue, emitter
// first character: the converter runs its conversion steps, then pushes the entry into
//   the queue (stalling while it is full), and the emitter loads it from the queue
// throughput: one character per cycle while the character stream is ready and the queue
//   holds an entry; up to 20 characters per value at width 64
// reset: synchronous active low, clears the converter state, queue pointers and emitter flag
`default_nettype none

module signed_integer_to_decimal_ascii
    import s2d_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [63:0] value
    // character stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] character
    output logic             o_m_axis_tlast    // last character of the value's text
);

    localparam int NDIG    = num_digits(VALUE_WIDTH);
    localparam int ENTRY_W = 1 + $clog2(NDIG) + NDIG * DIGIT_W;

    // queue entry: sign, index of top digit, bcd digits
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] back_entry;

    // converter: takes a value, splits sign, runs shift-add-3 four bits a cycle
    s2d_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata),
        .o_push  (push),
        .i_full  (full),
        .o_entry (front_entry)
    );

    // two-entry queue so conversion of the next item overlaps emission
    s2d_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (back_entry),
        .o_empty (empty)
    );

    // emitter: minus sign if any, then digits from the top nonzero one down
    s2d_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_entry  (back_entry),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
